// File: rtl/core/bchd_pkg.sv
// Package: widths, payload words and constants of the box corner Hausdorff distance unit.
`default_nettype none

package bchd_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int SIZE_WIDTH  = COORD_WIDTH - 1;
  // doubled endpoint / 1-D distance width
  localparam int DW          = COORD_WIDTH + 2;
  // root width and squared-sum width (SW = 2 * RW)
  localparam int RW          = DW + 1;
  localparam int SW          = 2 * RW;
  localparam int FRAC_BITS   = 16;
  localparam int QW          = 32;
  localparam int CMP_WIDTH   = (DW > QW + FRAC_BITS) ? DW : QW + FRAC_BITS;
  localparam logic [QW-1:0] SCALE_RESET = QW'(65536);

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] a_center_x;
    logic signed [COORD_WIDTH-1:0] a_center_y;
    logic signed [COORD_WIDTH-1:0] a_center_z;
    logic [SIZE_WIDTH-1:0]         a_size_x;
    logic [SIZE_WIDTH-1:0]         a_size_y;
    logic [SIZE_WIDTH-1:0]         a_size_z;
    logic signed [COORD_WIDTH-1:0] b_center_x;
    logic signed [COORD_WIDTH-1:0] b_center_y;
    logic signed [COORD_WIDTH-1:0] b_center_z;
    logic [SIZE_WIDTH-1:0]         b_size_x;
    logic [SIZE_WIDTH-1:0]         b_size_y;
    logic [SIZE_WIDTH-1:0]         b_size_z;
  } in_t;

  typedef struct packed {
    logic [DW-1:0] hausdorff_distance;
    logic [QW-1:0] dissimilarity;
    logic          saturated;
  } out_t;

endpackage

`default_nettype wire

// File: rtl/core/bchd_sqrt.sv
// Pipelined integer square root, one root bit per stage.
`default_nettype none

module bchd_sqrt import bchd_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [SW-1:0] in_sq_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [RW-1:0]      out_root_o
);

  logic          v_q    [RW];
  logic [SW-1:0] x_q    [RW];
  logic [RW+1:0] rem_q  [RW];
  logic [RW-1:0] root_q [RW];
  logic          en     [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic          v_in;
    logic [SW-1:0] x_in;
    logic [RW+1:0] rem_in;
    logic [RW-1:0] root_in;
    logic [RW+1:0] rem_sh;
    logic [RW+1:0] trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign v_in    = in_valid_i;
      assign x_in    = in_sq_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign x_in    = x_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    if (k == RW - 1) begin : g_last_en
      assign en[k] = !v_q[k] || out_ready_i;
    end else begin : g_mid_en
      assign en[k] = !v_q[k] || en[k+1];
    end

    always_comb begin
      rem_sh = {rem_in[RW-1:0], x_in[SW-1:SW-2]};
      trial  = {root_in, 2'b01};
      ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        x_q[k]    <= {x_in[SW-3:0], 2'b00};
        rem_q[k]  <= ge ? (rem_sh - trial) : rem_sh;
        root_q[k] <= {root_in[RW-2:0], ge};
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[RW-1];
  assign out_root_o  = root_q[RW-1];

endmodule

`default_nettype wire

// File: rtl/core/bchd_div.sv
// Saturation check and pipelined restoring divide of distance by scale, one bit per stage.
`default_nettype none

module bchd_div import bchd_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [DW-1:0] in_hd_i,
  input  wire logic [QW-1:0] scale_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output out_t               out_data_o
);

  // prep stage
  logic                 pv_q;
  logic [DW-1:0]        phd_q;
  logic                 psat_q;
  logic [QW:0]          prem_q;
  logic [QW-1:0]        plo_q;
  logic                 pen;
  logic [DW+FRAC_BITS-1:0] num;
  logic                 sat;

  logic          v_q    [QW];
  logic [DW-1:0] hd_q   [QW];
  logic          sat_q  [QW];
  logic [QW:0]   rem_q  [QW];
  logic [QW-1:0] lo_q   [QW];
  logic [QW-1:0] quot_q [QW];
  logic          en     [QW];

  always_comb begin
    num = {in_hd_i, {FRAC_BITS{1'b0}}};
    sat = (scale_i == '0) ||
          (CMP_WIDTH'(in_hd_i) >= CMP_WIDTH'({scale_i, {FRAC_BITS{1'b0}}}));
  end

  assign pen = !pv_q || en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else if (pen) begin
      pv_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pen) begin
      phd_q  <= in_hd_i;
      psat_q <= sat;
      // top part is below scale whenever the quotient fits
      prem_q <= (QW+1)'(num >> QW);
      plo_q  <= num[QW-1:0];
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic          v_in;
    logic [DW-1:0] hd_in;
    logic          sat_in;
    logic [QW:0]   rem_in;
    logic [QW-1:0] lo_in;
    logic [QW-1:0] quot_in;
    logic [QW:0]   rem_sh;
    logic          ge;

    if (k == 0) begin : g_first
      assign v_in    = pv_q;
      assign hd_in   = phd_q;
      assign sat_in  = psat_q;
      assign rem_in  = prem_q;
      assign lo_in   = plo_q;
      assign quot_in = '0;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign hd_in   = hd_q[k-1];
      assign sat_in  = sat_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign lo_in   = lo_q[k-1];
      assign quot_in = quot_q[k-1];
    end

    if (k == QW - 1) begin : g_last_en
      assign en[k] = !v_q[k] || out_ready_i;
    end else begin : g_mid_en
      assign en[k] = !v_q[k] || en[k+1];
    end

    always_comb begin
      rem_sh = {rem_in[QW-1:0], lo_in[QW-1]};
      ge     = (rem_sh >= {1'b0, scale_i});
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        hd_q[k]   <= hd_in;
        sat_q[k]  <= sat_in;
        rem_q[k]  <= ge ? (rem_sh - {1'b0, scale_i}) : rem_sh;
        lo_q[k]   <= {lo_in[QW-2:0], 1'b0};
        quot_q[k] <= {quot_in[QW-2:0], ge};
      end
    end
  end

  assign in_ready_o  = pen;
  assign out_valid_o = v_q[QW-1];

  always_comb begin
    out_data_o.hausdorff_distance = hd_q[QW-1];
    out_data_o.saturated          = sat_q[QW-1];
    out_data_o.dissimilarity      = sat_q[QW-1] ? '1 : quot_q[QW-1];
  end

endmodule

`default_nettype wire

// File: rtl/core/box_corner_hausdorff_distance_unit.sv
// Top level: corner-set Hausdorff distance of two boxes, with scaled dissimilarity.
//
//  channel  signals                         dir  word
//  in       in_valid_i/in_ready_o           in   in_t (two boxes)
//  out      out_valid_o/out_ready_i         out  out_t (distance, dissimilarity, flag)
//  cfg      cfg_we_i/cfg_data_i             in   distance_scale, 32 bits
//
// One word per cycle sustained while out_ready_i is high. There are 7 front stages,
// 35 square-root stages and 33 divide stages, set by the bit-per-stage root and divider.
// Reset clears all valid bits and loads scale 1.0.
// Each stage holds while it is full and the one after it cannot take its word,
// so bubbles are squeezed out and a stalled output still lets words enter.
`default_nettype none

module box_corner_hausdorff_distance_unit import bchd_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire in_t           in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output out_t               out_data_o,
  input  wire logic          cfg_we_i,
  input  wire logic [QW-1:0] cfg_data_i
);

  localparam int L = DW / 2;
  localparam int H = DW - L;

  logic [QW-1:0] scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RESET;
    end else if (cfg_we_i) begin
      scale_q <= cfg_data_i;
    end
  end

  logic signed [COORD_WIDTH-1:0] ca [3];
  logic signed [COORD_WIDTH-1:0] cb [3];
  logic [SIZE_WIDTH-1:0]         sa [3];
  logic [SIZE_WIDTH-1:0]         sb [3];

  assign ca[0] = in_data_i.a_center_x;
  assign ca[1] = in_data_i.a_center_y;
  assign ca[2] = in_data_i.a_center_z;
  assign cb[0] = in_data_i.b_center_x;
  assign cb[1] = in_data_i.b_center_y;
  assign cb[2] = in_data_i.b_center_z;
  assign sa[0] = in_data_i.a_size_x;
  assign sa[1] = in_data_i.a_size_y;
  assign sa[2] = in_data_i.a_size_z;
  assign sb[0] = in_data_i.b_size_x;
  assign sb[1] = in_data_i.b_size_y;
  assign sb[2] = in_data_i.b_size_z;

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;
  logic en1, en2, en3, en4, en5, en6, en7;
  logic sq_ready;

  assign en7 = !v7_q || sq_ready;
  assign en6 = !v6_q || en7;
  assign en5 = !v5_q || en6;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
      if (en6) v6_q <= v5_q;
      if (en7) v7_q <= v6_q;
    end
  end

  // stage 1: doubled endpoints 2c -+ s, order a0 a1 b0 b1
  logic signed [DW-1:0] pt_d [3][4];
  logic signed [DW-1:0] pt_q [3][4];

  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      logic signed [DW-1:0] c2a, c2b, ea, eb;
      c2a = {ca[ax][COORD_WIDTH-1], ca[ax], 1'b0};
      c2b = {cb[ax][COORD_WIDTH-1], cb[ax], 1'b0};
      ea  = DW'(sa[ax]);
      eb  = DW'(sb[ax]);
      pt_d[ax][0] = c2a - ea;
      pt_d[ax][1] = c2a + ea;
      pt_d[ax][2] = c2b - eb;
      pt_d[ax][3] = c2b + eb;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) pt_q <= pt_d;
  end

  // stage 2: corner pair distances d00 d01 d10 d11 (shared by both directions)
  logic [DW-1:0] dist_d [3][4];
  logic [DW-1:0] dist_q [3][4];

  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      for (int j = 0; j < 4; j++) begin
        logic signed [DW:0] df;
        df = {pt_q[ax][j/2][DW-1], pt_q[ax][j/2]} -
             {pt_q[ax][2 + j%2][DW-1], pt_q[ax][2 + j%2]};
        dist_d[ax][j] = df[DW] ? DW'(-df) : DW'(df);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) dist_q <= dist_d;
  end

  // stage 3: directed 1-D distances, a->b in 0..2, b->a in 3..5
  logic [DW-1:0] dir_d [6];
  logic [DW-1:0] dir_q [6];

  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      logic [DW-1:0] m0, m1, n0, n1;
      m0 = (dist_q[ax][0] < dist_q[ax][1]) ? dist_q[ax][0] : dist_q[ax][1];
      m1 = (dist_q[ax][2] < dist_q[ax][3]) ? dist_q[ax][2] : dist_q[ax][3];
      n0 = (dist_q[ax][0] < dist_q[ax][2]) ? dist_q[ax][0] : dist_q[ax][2];
      n1 = (dist_q[ax][1] < dist_q[ax][3]) ? dist_q[ax][1] : dist_q[ax][3];
      dir_d[ax]     = (m0 > m1) ? m0 : m1;
      dir_d[3 + ax] = (n0 > n1) ? n0 : n1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) dir_q <= dir_d;
  end

  // stage 4: partial products of each square
  logic [2*H-1:0] hh_q [6];
  logic [H+L-1:0] hl_q [6];
  logic [2*L-1:0] ll_q [6];

  always_ff @(posedge clk_i) begin
    if (en4) begin
      for (int i = 0; i < 6; i++) begin
        hh_q[i] <= dir_q[i][DW-1:L] * dir_q[i][DW-1:L];
        hl_q[i] <= dir_q[i][DW-1:L] * dir_q[i][L-1:0];
        ll_q[i] <= dir_q[i][L-1:0] * dir_q[i][L-1:0];
      end
    end
  end

  // stage 5: squares
  logic [2*DW-1:0] sq_q [6];

  always_ff @(posedge clk_i) begin
    if (en5) begin
      for (int i = 0; i < 6; i++) begin
        sq_q[i] <= ((2*DW)'(hh_q[i]) << (2*L)) + ((2*DW)'(hl_q[i]) << (L+1)) +
                   (2*DW)'(ll_q[i]);
      end
    end
  end

  // stage 6: directed squared distances
  logic [SW-1:0] sab_q, sba_q;

  always_ff @(posedge clk_i) begin
    if (en6) begin
      sab_q <= SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]);
      sba_q <= SW'(sq_q[3]) + SW'(sq_q[4]) + SW'(sq_q[5]);
    end
  end

  // stage 7: larger direction
  logic [SW-1:0] s_q;

  always_ff @(posedge clk_i) begin
    if (en7) s_q <= (sab_q > sba_q) ? sab_q : sba_q;
  end

  logic          rt_valid, rt_ready;
  logic [RW-1:0] rt_root;

  bchd_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v7_q),
    .in_ready_o  (sq_ready),
    .in_sq_i     (s_q),
    .out_valid_o (rt_valid),
    .out_ready_i (rt_ready),
    .out_root_o  (rt_root)
  );

  // root is in doubled units: halve it
  bchd_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rt_valid),
    .in_ready_o  (rt_ready),
    .in_hd_i     (rt_root[RW-1:1]),
    .scale_i     (scale_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  a_sat_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.saturated |-> out_data_o.dissimilarity == '1)
    else $error("saturated word without clipped dissimilarity");

  a_unsat_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.saturated |->
      CMP_WIDTH'(out_data_o.hausdorff_distance) <
      CMP_WIDTH'({scale_q, {FRAC_BITS{1'b0}}}))
    else $error("unsaturated word whose quotient overflows");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input refused while output is not stalled");

endmodule

`default_nettype wire

// File: verif/tb_box_corner_hausdorff_distance_unit.sv
// Testbench: box corner Hausdorff distance unit against a behavioral predictor.
`default_nettype none

module tb_box_corner_hausdorff_distance_unit;
  import bchd_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [QW-1:0] cfg_data_i = '0;

  box_corner_hausdorff_distance_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i)
  );

  localparam int LATENCY = 75;
  localparam int CFG_INDEX_SCALE = 0;

  always #4 clk_i = ~clk_i;

  out_t pending_results[$];
  logic [QW-1:0] scale_q = SCALE_RESET;
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  // 1-D directed distance between doubled endpoint pairs
  function automatic logic [63:0] axis_dir(input longint p0, input longint p1,
                                           input longint q0, input longint q1);
    longint d00, d01, d10, d11, m0, m1;
    d00 = p0 - q0; if (d00 < 0) d00 = -d00;
    d01 = p0 - q1; if (d01 < 0) d01 = -d01;
    d10 = p1 - q0; if (d10 < 0) d10 = -d10;
    d11 = p1 - q1; if (d11 < 0) d11 = -d11;
    m0 = (d00 < d01) ? d00 : d01;
    m1 = (d10 < d11) ? d10 : d11;
    return (m0 > m1) ? m0 : m1;
  endfunction

  function automatic out_t box_distance(input in_t w, input logic [QW-1:0] scale);
    logic [127:0] sab, sba, s, t2;
    logic [63:0] root, t, dab, dba, hd;
    longint ca[3], cb[3], sa[3], sb[3];
    out_t r;
    ca[0] = 2 * longint'(w.a_center_x); ca[1] = 2 * longint'(w.a_center_y);
    ca[2] = 2 * longint'(w.a_center_z);
    cb[0] = 2 * longint'(w.b_center_x); cb[1] = 2 * longint'(w.b_center_y);
    cb[2] = 2 * longint'(w.b_center_z);
    sa[0] = longint'({1'b0, w.a_size_x}); sa[1] = longint'({1'b0, w.a_size_y});
    sa[2] = longint'({1'b0, w.a_size_z});
    sb[0] = longint'({1'b0, w.b_size_x}); sb[1] = longint'({1'b0, w.b_size_y});
    sb[2] = longint'({1'b0, w.b_size_z});
    sab = '0; sba = '0;
    for (int ax = 0; ax < 3; ax++) begin
      dab = axis_dir(ca[ax] - sa[ax], ca[ax] + sa[ax], cb[ax] - sb[ax], cb[ax] + sb[ax]);
      dba = axis_dir(cb[ax] - sb[ax], cb[ax] + sb[ax], ca[ax] - sa[ax], ca[ax] + sa[ax]);
      sab += {64'd0, dab} * {64'd0, dab};
      sba += {64'd0, dba} * {64'd0, dba};
    end
    s = (sab <= sba) ? sba : sab;
    root = '0;
    for (int b = 62; b >= 0; b--) begin
      t = root | (64'd1 << b);
      t2 = {64'd0, t} * {64'd0, t};
      if (t2 <= s) root = t;
    end
    hd = root >> 1;
    r.hausdorff_distance = hd[DW-1:0];
    if (scale == 0 || hd >= ({32'd0, scale} << 16)) begin
      r.dissimilarity = '1;
      r.saturated = 1'b1;
    end else begin
      r.dissimilarity = QW'((hd << 16) / {32'd0, scale});
      r.saturated = 1'b0;
    end
    return r;
  endfunction

  function automatic in_t random_boxes(input int mode);
    in_t w;
    w = $bits(in_t)'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    if (mode == 1) begin
      // nearby small boxes: realistic range
      w.b_center_x = w.a_center_x + $signed(32'($urandom_range(0, 131072)) - 65536);
      w.b_center_y = w.a_center_y + $signed(32'($urandom_range(0, 131072)) - 65536);
      w.b_center_z = w.a_center_z + $signed(32'($urandom_range(0, 131072)) - 65536);
      w.a_size_x = SIZE_WIDTH'($urandom_range(0, 1 << 20));
      w.a_size_y = SIZE_WIDTH'($urandom_range(0, 1 << 20));
      w.a_size_z = SIZE_WIDTH'($urandom_range(0, 1 << 20));
      w.b_size_x = SIZE_WIDTH'($urandom_range(0, 1 << 20));
      w.b_size_y = SIZE_WIDTH'($urandom_range(0, 1 << 20));
      w.b_size_z = SIZE_WIDTH'($urandom_range(0, 1 << 20));
    end else if (mode == 2) begin
      w.a_size_x = '0; w.a_size_y = '0; w.a_size_z = '0;
      w.b_size_x = '0; w.b_size_y = '0; w.b_size_z = '0;
    end
    return w;
  endfunction

  // receiver: random stall, plus long hold-off
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report("unexpected word", 64'(out_data_o), 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.hausdorff_distance !== want.hausdorff_distance)
          report("hausdorff_distance", 64'(out_data_o.hausdorff_distance),
                 64'(want.hausdorff_distance));
        if (out_data_o.dissimilarity !== want.dissimilarity)
          report("dissimilarity", 64'(out_data_o.dissimilarity), 64'(want.dissimilarity));
        if (out_data_o.saturated !== want.saturated)
          report("saturated", 64'(out_data_o.saturated), 64'(want.saturated));
      end
    end
  end

  // valid stays up across back-to-back words; it drops only in idle cycles and in drain
  task automatic send_word(input in_t w);
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    pending_results.push_back(box_distance(w, scale_q));
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic write_scale(input logic [QW-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    scale_q = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  typedef struct {
    in_t w;
    logic known;
    out_t want;
  } directed_row_t;

  directed_row_t directed_rows[$];

  initial begin
    directed_row_t row;
    in_t w;
    logic [QW-1:0] scales[6];
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: identical boxes, points, extremes
    row.w = '0; row.known = 1'b1; row.want = '0; directed_rows.push_back(row);
    w = '0; w.b_center_x = 32'sh0001_0000;
    row.w = w; row.want = '{hausdorff_distance: 34'h1_0000, dissimilarity: 32'h1_0000,
                             saturated: 1'b0};
    directed_rows.push_back(row);
    row.known = 1'b0;
    w = '0; w.a_center_x = 32'sh8000_0000; w.a_center_y = 32'sh8000_0000;
    w.a_center_z = 32'sh8000_0000; w.b_center_x = 32'sh7fff_ffff;
    w.b_center_y = 32'sh7fff_ffff; w.b_center_z = 32'sh7fff_ffff;
    row.w = w; directed_rows.push_back(row);
    w = '1; row.w = w; directed_rows.push_back(row);
    w = '0; w.a_size_x = '1; w.a_size_y = '1; w.a_size_z = '1;
    row.w = w; directed_rows.push_back(row);
    w.b_size_x = '1; w.b_size_y = '1; w.b_size_z = '1;
    w.a_center_x = 32'sh7fff_ffff; w.b_center_x = 32'sh8000_0000;
    row.w = w; directed_rows.push_back(row);
    w = '0; w.a_size_y = 31'h0000_0001; w.b_size_z = 31'h0000_0003;
    row.w = w; directed_rows.push_back(row);
    for (int i = 0; i < 12; i++) begin
      row.w = random_boxes(i % 3); directed_rows.push_back(row);
    end
    foreach (directed_rows[i]) begin
      if (directed_rows[i].known)
        assert (box_distance(directed_rows[i].w, scale_q) == directed_rows[i].want)
          else report("directed table", 64'd0, 64'(i));
      send_word(directed_rows[i].w);
    end
    drain();

    scales[0] = 32'd0; scales[1] = 32'd1; scales[2] = 32'hffff_ffff;
    scales[3] = 32'h0000_8000; scales[4] = SCALE_RESET; scales[5] = 32'h0100_0000;
    for (int ph = 0; ph < 6; ph++) begin
      write_scale(ph == 5 ? $urandom_range(1, 32'hffff_ffff) : scales[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 47; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 47; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      if (ph == 0) hold_off = 300;
      for (int i = 0; i < 320; i++) send_word(random_boxes($urandom_range(0, 2)));
      drain();
    end
    write_scale(CFG_INDEX_SCALE == 0 ? SCALE_RESET : '0);
    send_idle_pct = 0; recv_stall_pct = 0;
    for (int i = 0; i < 10; i++) send_word(random_boxes(1));
    drain();

    if (errors == 0) begin
      $display("tb_box_corner_hausdorff_distance_unit: PASS");
    end else begin
      $display("tb_box_corner_hausdorff_distance_unit: FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb_box_corner_hausdorff_distance_unit: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
